/* rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with reset gating
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("page table manager check failed");

// shorthand for the usual clk and rst_n names
`define PTM_ASSERT(lbl, prop) `ASSERT_CLK(lbl, clk, rst_n, prop)

`endif

/* rtl/ptm_pkg.sv */
// types and constants of the page table manager
`timescale 1ns / 1ps
package ptm_pkg;

  localparam int DIR_ENTRIES   = 1024;
  localparam int TABLE_ENTRIES = 1024;
  localparam int SLOT_W  = $clog2(DIR_ENTRIES);
  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int OFF_W   = 12;
  localparam int FRAME_W = 20;
  localparam int FLAG_W  = 12;
  localparam int ENT_W   = 32;
  localparam int ADDR_W  = 32;
  localparam int REQ_W   = 3;
  localparam int STAT_W  = 2;
  localparam int DIR_W   = FRAME_W + 1;
  localparam int EADDR_W = SLOT_W + IDX_W;

  localparam logic [SLOT_W-1:0] RESERVED_SLOT = SLOT_W'(DIR_ENTRIES - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT     = SLOT_W'(DIR_ENTRIES - 1);
  localparam logic [IDX_W-1:0]  LAST_IDX      = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [REQ_W-1:0] REQ_MAP   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_UNMAP = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SET   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CLR   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_GET   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_XLATE = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_MAPPED   = 2'd1;
  localparam logic [STAT_W-1:0] ST_RESERVED = 2'd2;
  localparam logic [STAT_W-1:0] ST_ABSENT   = 2'd3;

  localparam logic [ENT_W-1:0]  ENT_WRITE_ONLY = 32'h0000_0002;
  localparam logic [FLAG_W-1:0] ENT_MAPPED_LOW = 12'h003;

  typedef struct packed {
    logic [REQ_W-1:0]   req;
    logic               ignore;
    logic               reserved;
    logic [SLOT_W-1:0]  slot;
    logic [IDX_W-1:0]   idx;
    logic [OFF_W-1:0]   off;
    logic [FRAME_W-1:0] pa_frame;
    logic [FLAG_W-1:0]  flags;
    logic [FRAME_W-1:0] tf;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [ADDR_W-1:0]  phys_addr;
    logic [FLAG_W-1:0]  page_flags;
    logic               table_allocated;
    logic               frame_freed;
    logic [FRAME_W-1:0] freed_frame;
    logic               tlb_flush;
  } res_t;

endpackage

/* rtl/ptm_ifs.sv */
// request and result channel interfaces
`timescale 1ns / 1ps
interface ptm_in_if;
  logic                         valid;
  logic                         ready;
  logic [ptm_pkg::REQ_W-1:0]    req_type;
  logic [ptm_pkg::ADDR_W-1:0]   vaddr;
  logic [ptm_pkg::ADDR_W-1:0]   paddr;
  logic [ptm_pkg::FLAG_W-1:0]   flags;
  logic [ptm_pkg::FRAME_W-1:0]  table_frame;
  modport source (output valid, req_type, vaddr, paddr, flags, table_frame, input ready);
  modport sink   (input valid, req_type, vaddr, paddr, flags, table_frame, output ready);
endinterface

interface ptm_out_if;
  logic                         valid;
  logic                         ready;
  logic [ptm_pkg::STAT_W-1:0]   status;
  logic [ptm_pkg::ADDR_W-1:0]   phys_addr;
  logic [ptm_pkg::FLAG_W-1:0]   page_flags;
  logic                         table_allocated;
  logic                         frame_freed;
  logic [ptm_pkg::FRAME_W-1:0]  freed_frame;
  logic                         tlb_flush;
  modport source (output valid, status, phys_addr, page_flags, table_allocated,
                  frame_freed, freed_frame, tlb_flush, input ready);
  modport sink   (input valid, status, phys_addr, page_flags, table_allocated,
                  frame_freed, freed_frame, tlb_flush, output ready);
endinterface

/* rtl/ptm_front.sv */
// request decode and two-entry command queue
`timescale 1ns / 1ps
module ptm_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          init_done,
  ptm_in_if.sink        in_req,
  output ptm_pkg::cmd_t q_cmd,
  output logic          q_valid,
  input  logic          q_pop
);

  ptm_pkg::cmd_t q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  ptm_pkg::cmd_t dec;

  assign in_req.ready = init_done && (cnt_r != 2'd2);
  assign q_valid      = (cnt_r != 2'd0);
  assign q_cmd        = q_mem_r[rd_ptr_r];
  assign push         = in_req.valid && in_req.ready;
  assign pop          = q_pop && q_valid;

  always_comb begin
    dec.req      = in_req.req_type;
    dec.ignore   = (in_req.req_type > ptm_pkg::REQ_XLATE);
    dec.slot     = in_req.vaddr[31:22];
    dec.reserved = (in_req.vaddr[31:22] == ptm_pkg::RESERVED_SLOT);
    dec.idx      = in_req.vaddr[21:12];
    dec.off      = in_req.vaddr[11:0];
    dec.pa_frame = in_req.paddr[31:12];
    dec.flags    = in_req.flags;
    dec.tf       = in_req.table_frame;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec;
    end
  end

endmodule

/* rtl/ptm_back.sv */
// execution engine: directory and entry memories, table fill and empty scan
`timescale 1ns / 1ps
module ptm_back (
  input  logic          clk,
  input  logic          rst_n,
  output logic          init_done,
  input  ptm_pkg::cmd_t q_cmd,
  input  logic          q_valid,
  output logic          q_pop,
  output logic          out_valid,
  output ptm_pkg::res_t out_res,
  input  logic          out_ready
);

  localparam logic [3:0] S_CLR      = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DIR      = 4'd2;
  localparam logic [3:0] S_FILL     = 4'd3;
  localparam logic [3:0] S_MAPW     = 4'd4;
  localparam logic [3:0] S_ENT      = 4'd5;
  localparam logic [3:0] S_SCAN     = 4'd6;
  localparam logic [3:0] S_SCAN_END = 4'd7;
  localparam logic [3:0] S_OUT      = 4'd8;

  logic [ptm_pkg::DIR_W-1:0] dir_mem [ptm_pkg::DIR_ENTRIES];
  logic [ptm_pkg::ENT_W-1:0] ent_mem [ptm_pkg::DIR_ENTRIES * ptm_pkg::TABLE_ENTRIES];

  logic [3:0]                  state_r, state_nxt;
  logic [ptm_pkg::IDX_W-1:0]   cnt_r, cnt_nxt;
  ptm_pkg::cmd_t               cmd_r, cmd_nxt;
  ptm_pkg::res_t               res_r, res_nxt;
  ptm_pkg::res_t               out_res_r, out_res_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        any_r, any_nxt;
  logic                        scan_vld_r, scan_vld_nxt;
  logic [ptm_pkg::DIR_W-1:0]   dir_q_r;
  logic [ptm_pkg::ENT_W-1:0]   ent_q_r;

  logic                         dir_we, dir_re;
  logic [ptm_pkg::SLOT_W-1:0]   dir_wa, dir_ra;
  logic [ptm_pkg::DIR_W-1:0]    dir_wd;
  logic                         ent_we, ent_re;
  logic [ptm_pkg::EADDR_W-1:0]  ent_wa, ent_ra;
  logic [ptm_pkg::ENT_W-1:0]    ent_wd;
  logic                         any_all;

  assign init_done = (state_r != S_CLR);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign any_all   = any_r | ent_q_r[0];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd_nxt       = cmd_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    any_nxt       = any_r;
    scan_vld_nxt  = 1'b0;
    q_pop         = 1'b0;
    dir_we        = 1'b0;
    dir_wa        = cmd_r.slot;
    dir_wd        = '0;
    dir_re        = 1'b0;
    dir_ra        = q_cmd.slot;
    ent_we        = 1'b0;
    ent_wa        = {cmd_r.slot, cmd_r.idx};
    ent_wd        = ptm_pkg::ENT_WRITE_ONLY;
    ent_re        = 1'b0;
    ent_ra        = {cmd_r.slot, cmd_r.idx};

    unique case (state_r)
      S_CLR: begin
        dir_we  = 1'b1;
        dir_wa  = cnt_r;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ptm_pkg::LAST_SLOT) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_cmd;
          dir_re    = 1'b1;
          state_nxt = S_DIR;
        end
      end
      S_DIR: begin
        res_nxt = '0;
        cnt_nxt = '0;
        if (cmd_r.ignore) begin
          state_nxt = S_OUT;
        end else if (cmd_r.reserved) begin
          res_nxt.status = ptm_pkg::ST_RESERVED;
          state_nxt      = S_OUT;
        end else if (cmd_r.req == ptm_pkg::REQ_MAP && !dir_q_r[ptm_pkg::FRAME_W]) begin
          dir_we    = 1'b1;
          dir_wd    = {1'b1, cmd_r.tf};
          state_nxt = S_FILL;
        end else if (!dir_q_r[ptm_pkg::FRAME_W]) begin
          res_nxt.status = ptm_pkg::ST_ABSENT;
          state_nxt      = S_OUT;
        end else begin
          ent_re    = 1'b1;
          state_nxt = S_ENT;
        end
      end
      S_FILL: begin
        // new table: every entry write-only, not present
        ent_we  = 1'b1;
        ent_wa  = {cmd_r.slot, cnt_r};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ptm_pkg::LAST_IDX) begin
          state_nxt = S_MAPW;
        end
      end
      S_MAPW: begin
        ent_we                  = 1'b1;
        ent_wd                  = {cmd_r.pa_frame, ptm_pkg::ENT_MAPPED_LOW};
        res_nxt.table_allocated = 1'b1;
        res_nxt.tlb_flush       = 1'b1;
        state_nxt               = S_OUT;
      end
      S_ENT: begin
        state_nxt = S_OUT;
        case (cmd_r.req)
          ptm_pkg::REQ_MAP: begin
            if (ent_q_r[0]) begin
              res_nxt.status = ptm_pkg::ST_MAPPED;
            end else begin
              ent_we            = 1'b1;
              ent_wd            = {cmd_r.pa_frame, ptm_pkg::ENT_MAPPED_LOW};
              res_nxt.tlb_flush = 1'b1;
            end
          end
          ptm_pkg::REQ_UNMAP: begin
            ent_we    = 1'b1;
            any_nxt   = 1'b0;
            state_nxt = S_SCAN;
          end
          ptm_pkg::REQ_SET: begin
            ent_we = 1'b1;
            ent_wd = ent_q_r | {20'd0, cmd_r.flags};
          end
          ptm_pkg::REQ_CLR: begin
            ent_we = 1'b1;
            ent_wd = ent_q_r & ~{20'd0, cmd_r.flags};
          end
          ptm_pkg::REQ_GET: begin
            res_nxt.page_flags = ent_q_r[11:0];
          end
          ptm_pkg::REQ_XLATE: begin
            res_nxt.phys_addr = {ent_q_r[31:12], 12'd0} + {20'd0, cmd_r.off};
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        // read data arrives in the cycle after the read address
        ent_re       = 1'b1;
        ent_ra       = {cmd_r.slot, cnt_r};
        scan_vld_nxt = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (scan_vld_r) begin
          any_nxt = any_all;
        end
        if (cnt_r == ptm_pkg::LAST_IDX) begin
          state_nxt = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        if (!any_all) begin
          dir_we              = 1'b1;
          res_nxt.frame_freed = 1'b1;
          res_nxt.freed_frame = dir_q_r[ptm_pkg::FRAME_W-1:0];
          res_nxt.tlb_flush   = 1'b1;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_res_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      any_r       <= 1'b0;
      scan_vld_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      any_r       <= any_nxt;
      scan_vld_r  <= scan_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_wa] <= dir_wd;
    end
    if (dir_re) begin
      dir_q_r <= dir_mem[dir_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_wa] <= ent_wd;
    end
    if (ent_re) begin
      ent_q_r <= ent_mem[ent_ra];
    end
  end

endmodule

/* rtl/two_level_page_table_manager_top.sv */
// Two-level page table manager, top level.
// After reset the directory is cleared entry by entry; no request is taken then.
// Lookup requests: from queue head to result register via directory read, entry
// read and update; the next is taken only once the last is done. Map into an absent
// slot adds a table fill; unmap adds a scan over the single entry read port.
// A two-request queue in front keeps taking requests, until full, while a result waits.
`timescale 1ns / 1ps
module two_level_page_table_manager_top (
  input  logic      clk,
  input  logic      rst_n,
  ptm_in_if.sink    in_req,
  ptm_out_if.source out_rsp
);

  ptm_pkg::cmd_t q_cmd;
  logic          q_valid;
  logic          q_pop;
  logic          init_done;
  logic          res_valid;
  ptm_pkg::res_t res;

  ptm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .init_done (init_done),
    .in_req    (in_req),
    .q_cmd     (q_cmd),
    .q_valid   (q_valid),
    .q_pop     (q_pop)
  );

  ptm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .init_done (init_done),
    .q_cmd     (q_cmd),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .out_valid (res_valid),
    .out_res   (res),
    .out_ready (out_rsp.ready)
  );

  assign out_rsp.valid           = res_valid;
  assign out_rsp.status          = res.status;
  assign out_rsp.phys_addr       = res.phys_addr;
  assign out_rsp.page_flags      = res.page_flags;
  assign out_rsp.table_allocated = res.table_allocated;
  assign out_rsp.frame_freed     = res.frame_freed;
  assign out_rsp.freed_frame     = res.freed_frame;
  assign out_rsp.tlb_flush       = res.tlb_flush;

endmodule

/* rtl/ptm_checker.sv */
// port-level checks on the result channel, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ptm_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ptm_pkg::STAT_W-1:0]   status,
  input logic                         table_allocated,
  input logic                         frame_freed,
  input logic [ptm_pkg::FRAME_W-1:0]  freed_frame,
  input logic                         tlb_flush
);

  `PTM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(freed_frame))
  `PTM_ASSERT(a_freed_zero, out_valid && !frame_freed |-> freed_frame == '0)
  `PTM_ASSERT(a_free_flush, out_valid && frame_freed |-> tlb_flush && status == ptm_pkg::ST_OK && !table_allocated)
  `PTM_ASSERT(a_alloc_flush, out_valid && table_allocated |-> tlb_flush && status == ptm_pkg::ST_OK)

endmodule

bind two_level_page_table_manager_top ptm_checker u_ptm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_rsp.valid),
  .out_ready       (out_rsp.ready),
  .status          (out_rsp.status),
  .table_allocated (out_rsp.table_allocated),
  .frame_freed     (out_rsp.frame_freed),
  .freed_frame     (out_rsp.freed_frame),
  .tlb_flush       (out_rsp.tlb_flush)
);

/* tb/ptm_scoreboard.sv */
// page table predictor and result scoreboard
`timescale 1ns / 1ps
package ptm_sb_pkg;
  import ptm_pkg::*;

  class ptm_scoreboard;
    logic [DIR_W-1:0] dir[DIR_ENTRIES];
    logic [ENT_W-1:0] pte[int unsigned];
    res_t pending[$];
    int errors;

    function new();
      foreach (dir[i]) dir[i] = '0;
      errors = 0;
    endfunction

    function logic [ENT_W-1:0] rd(int unsigned a);
      if (pte.exists(a)) return pte[a];
      return '0;
    endfunction

    function bit tbl_empty(int unsigned s);
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (rd(s * TABLE_ENTRIES + i) & 32'h1) return 0;
      return 1;
    endfunction

    function bit slot_present(int unsigned s);
      return dir[s][FRAME_W];
    endfunction

    // work out the result of one accepted request
    function void note_request(logic [REQ_W-1:0] rq, logic [ADDR_W-1:0] va,
                               logic [ADDR_W-1:0] pa, logic [FLAG_W-1:0] fl,
                               logic [FRAME_W-1:0] tf);
      res_t r;
      int unsigned s, a;
      logic [ENT_W-1:0] e;
      r = '0;
      s = va[31:22];
      a = s * TABLE_ENTRIES + va[21:12];
      if (rq > REQ_XLATE) begin
      end else if (s == DIR_ENTRIES - 1) begin
        r.status = ST_RESERVED;
      end else if (rq == REQ_MAP) begin
        if (!dir[s][FRAME_W]) begin
          dir[s] = {1'b1, tf};
          for (int i = 0; i < TABLE_ENTRIES; i++) pte[s * TABLE_ENTRIES + i] = ENT_WRITE_ONLY;
          r.table_allocated = 1;
        end
        if (rd(a) & 32'h1) r.status = ST_MAPPED;
        else begin
          pte[a] = {pa[31:12], ENT_MAPPED_LOW};
          r.tlb_flush = 1;
        end
      end else if (!dir[s][FRAME_W]) begin
        r.status = ST_ABSENT;
      end else if (rq == REQ_UNMAP) begin
        pte[a] = ENT_WRITE_ONLY;
        if (tbl_empty(s)) begin
          r.freed_frame = dir[s][FRAME_W-1:0];
          dir[s] = '0;
          r.frame_freed = 1;
          r.tlb_flush = 1;
        end
      end else if (rq == REQ_SET) begin
        pte[a] = rd(a) | {20'h0, fl};
      end else if (rq == REQ_CLR) begin
        pte[a] = rd(a) & ~{20'h0, fl};
      end else if (rq == REQ_GET) begin
        e = rd(a);
        r.page_flags = e[11:0];
      end else begin
        e = rd(a);
        r.phys_addr = {e[31:12], 12'h0} + {20'h0, va[11:0]};
      end
      pending.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", e, got);
      end
    endfunction
  endclass
endpackage

/* tb/tb_two_level_page_table_manager_top.sv */
// testbench top for the page table manager
`timescale 1ns / 1ps
module tb_two_level_page_table_manager_top;
  import ptm_pkg::*;
  import ptm_sb_pkg::*;

  logic clk;
  logic rst_n;
  longint cycles;
  bit calm;
  ptm_scoreboard sb;
  logic [SLOT_W-1:0] hot_slots[4];

  ptm_in_if  in_req();
  ptm_out_if out_rsp();

  two_level_page_table_manager_top i_dut (
    .clk(clk), .rst_n(rst_n), .in_req(in_req.sink), .out_rsp(out_rsp.source)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // limit: ~700 requests, each possibly a full table scan plus stalls, several times over
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 6000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function bit idle_now();
    return !calm && ($urandom_range(99) < 17);
  endfunction

  // result sink: ready toggles at negedge, compare at posedge
  initial begin
    out_rsp.ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_rsp.ready <= !idle_now();
    end
  end

  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      got.status = out_rsp.status;
      got.phys_addr = out_rsp.phys_addr;
      got.page_flags = out_rsp.page_flags;
      got.table_allocated = out_rsp.table_allocated;
      got.frame_freed = out_rsp.frame_freed;
      got.freed_frame = out_rsp.freed_frame;
      got.tlb_flush = out_rsp.tlb_flush;
      sb.check_result(got);
    end
  end

  // valid stays high into the next request unless an idle cycle comes between
  task automatic send_request(logic [REQ_W-1:0] rq, logic [ADDR_W-1:0] va,
                              logic [ADDR_W-1:0] pa, logic [FLAG_W-1:0] fl,
                              logic [FRAME_W-1:0] tf);
    while (idle_now()) begin
      in_req.valid <= 0;
      @(negedge clk);
    end
    in_req.valid <= 1;
    in_req.req_type <= rq;
    in_req.vaddr <= va;
    in_req.paddr <= pa;
    in_req.flags <= fl;
    in_req.table_frame <= tf;
    do @(posedge clk); while (!in_req.ready);
    sb.note_request(rq, va, pa, fl, tf);
    @(negedge clk);
  endtask

  function logic [ADDR_W-1:0] pick_vaddr();
    logic [ADDR_W-1:0] v;
    v = $urandom;
    case ($urandom_range(9))
      0: v[31:22] = RESERVED_SLOT;
      1, 2: ;
      default: begin
        v[31:22] = hot_slots[$urandom_range(3)];
        v[21:12] = 10'($urandom_range(3));
      end
    endcase
    return v;
  endfunction

  initial begin
    logic [REQ_W-1:0] rq;
    sb = new();
    cycles = 0;
    calm = 0;
    rst_n = 0;
    in_req.valid = 0;
    in_req.req_type = '0;
    in_req.vaddr = '0;
    in_req.paddr = '0;
    in_req.flags = '0;
    in_req.table_frame = '0;
    hot_slots = '{10'd0, 10'd1, 10'd513, 10'd1022};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed
    send_request(REQ_XLATE, 32'h0000_1234, '0, '0, '0);
    send_request(REQ_UNMAP, 32'h0000_1000, '0, '0, '0);
    send_request(REQ_MAP, 32'hFFC0_0000, 32'hFFFF_FFFF, 12'hfff, 20'hfffff);
    send_request(REQ_MAP, 32'h0000_0000, 32'hFFFF_FFFF, '0, 20'hfffff);
    send_request(REQ_MAP, 32'h0000_0000, 32'h1234_5678, '0, 20'h0);
    send_request(REQ_MAP, 32'h003F_F000, 32'h0000_0000, '0, 20'h5);
    send_request(REQ_XLATE, 32'h0000_0FFF, '0, '0, '0);
    send_request(REQ_XLATE, 32'h0000_1ABC, '0, '0, '0);
    send_request(REQ_SET, 32'h0000_1000, '0, 12'hfff, '0);
    send_request(REQ_GET, 32'h0000_1000, '0, '0, '0);
    send_request(REQ_CLR, 32'h0000_1000, '0, 12'hfff, '0);
    send_request(REQ_GET, 32'h0000_1000, '0, '0, '0);
    send_request(REQ_CLR, 32'h0000_0000, '0, 12'h001, '0);
    send_request(REQ_GET, 32'h0000_0000, '0, '0, '0);
    send_request(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hfff, 20'hfffff);
    send_request(3'd7, 32'h0000_0000, '0, '0, '0);
    send_request(REQ_UNMAP, 32'h0000_0000, '0, '0, '0);
    send_request(REQ_UNMAP, 32'h003F_F000, '0, '0, '0);
    send_request(REQ_GET, 32'h0000_0000, '0, '0, '0);
    send_request(REQ_UNMAP, 32'hFFC0_0000, '0, '0, '0);

    // random: mostly maps/unmaps on a few slots so tables get freed and rebuilt
    for (int n = 0; n < 650; n++) begin
      calm = (n >= 250 && n < 350);
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5: rq = REQ_MAP;
        6, 7, 8, 9, 10:   rq = REQ_UNMAP;
        11, 12:           rq = REQ_SET;
        13, 14:           rq = REQ_CLR;
        15, 16:           rq = REQ_GET;
        17, 18:           rq = REQ_XLATE;
        default:          rq = 3'($urandom_range(7));
      endcase
      send_request(rq, pick_vaddr(), $urandom, 12'($urandom), 20'($urandom));
    end
    in_req.valid <= 0;
    calm = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+rtl
rtl/ptm_pkg.sv
rtl/ptm_ifs.sv
rtl/ptm_front.sv
rtl/ptm_back.sv
rtl/two_level_page_table_manager_top.sv
rtl/ptm_checker.sv
tb/ptm_scoreboard.sv
tb/tb_two_level_page_table_manager_top.sv
